// File: hw/rtl/ple_pkg.sv
package ple_pkg;

	// widest cell index the chain supports
	localparam int MAX_IDXW = 10;

	typedef enum logic [2:0] {
		OP_APPEND   = 3'd0,
		OP_INSERT   = 3'd1,
		OP_READ     = 3'd2,
		OP_DEL_LAST = 3'd3,
		OP_DEL_POS  = 3'd4
	} op_e_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_RANGE = 2'd3
	} status_e_t;

	typedef enum logic [1:0] {
		CMD_HOLD = 2'd0,
		CMD_INS  = 2'd1,
		CMD_DEL  = 2'd2
	} cell_cmd_e_t;

	typedef enum logic {
		FSM_IDLE = 1'b0,
		FSM_EVAL = 1'b1
	} fsm_e_t;

	typedef struct packed {
		cell_cmd_e_t          cmd;
		logic [MAX_IDXW-1:0]  pos;
	} cell_ctl_t;

	localparam int IN_W       = 40;
	localparam int IN_USER_W  = 3;
	localparam int OUT_W      = 104;
	localparam int OUT_USER_W = 2;

endpackage

// File: hw/rtl/ple_cell.sv
module ple_cell #(
	parameter int IDX        = 0,
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ple_pkg::cell_ctl_t    ctl,
	input  logic [DATA_WIDTH-1:0] word,
	input  logic                  prev_valid,
	input  logic [DATA_WIDTH-1:0] prev_data,
	input  logic                  next_valid,
	input  logic [DATA_WIDTH-1:0] next_data,
	output logic                  valid,
	output logic [DATA_WIDTH-1:0] data
);
	import ple_pkg::*;

	localparam logic [MAX_IDXW-1:0] MY_IDX = MAX_IDXW'(IDX);

	logic                  valid_q;
	logic [DATA_WIDTH-1:0] data_q;
	logic                  valid_d;
	logic [DATA_WIDTH-1:0] data_d;

	always_comb begin
		valid_d = valid_q;
		data_d  = data_q;
		unique case (ctl.cmd)
			CMD_INS: begin
				// entries behind the insert point move one place toward the tail
				if (MY_IDX > ctl.pos) begin
					valid_d = prev_valid;
					data_d  = prev_data;
				end else if (MY_IDX == ctl.pos) begin
					valid_d = 1'b1;
					data_d  = word;
				end
			end
			CMD_DEL: begin
				if (MY_IDX >= ctl.pos) begin
					valid_d = next_valid;
					data_d  = next_data;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign valid = valid_q;
	assign data  = data_q;

endmodule

// File: hw/rtl/positional_list_engine_core.sv
// Bounded ordered list of CAPACITY words, usable as a list, a stack (tail is the
// top) and a queue (front is the head). Each input word carries one operation:
// append, insert before a position, read, delete the tail, or delete at a
// position; every operation returns exactly one result word with status, read
// data, count and the current first and last entries. The list lives in a row
// of cells that all shift or hold together, so an insert or delete updates
// the whole list when the word is accepted; the evaluate state then gathers
// read data, count and first and last entries into the output register, waiting
// while an untaken result holds it. A new word is taken only once that load is
// done; a result waiting at the output does not block the next accept.
module positional_list_engine_core #(
	parameter int CAPACITY   = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// position[4:0], value[36:5], zero pad[39:37]
	input  logic [ple_pkg::IN_W-1:0]        s_axis_tdata,
	// operation[2:0]
	input  logic [ple_pkg::IN_USER_W-1:0]   s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// read_data[31:0], count[36:32], first_word[68:37],
	// last_word[100:69], zero pad[103:101]
	output logic [ple_pkg::OUT_W-1:0]       m_axis_tdata,
	// status[1:0]
	output logic [ple_pkg::OUT_USER_W-1:0]  m_axis_tuser
);
	import ple_pkg::*;

	localparam int IDXW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNTW = $clog2(CAPACITY + 1);
	localparam logic [15:0] CAP16 = 16'(CAPACITY);

	// input fields
	logic [2:0]            in_op;
	logic [4:0]            in_pos;
	logic [31:0]           in_value;
	logic [63:0]           value_ext;
	logic [DATA_WIDTH-1:0] in_word;
	logic [15:0]           pos16;
	logic [15:0]           cnt16;

	assign in_op     = s_axis_tuser[2:0];
	assign in_pos    = s_axis_tdata[4:0];
	assign in_value  = s_axis_tdata[36:5];
	assign value_ext = 64'(in_value);
	assign in_word   = value_ext[DATA_WIDTH-1:0];
	assign pos16     = 16'(in_pos);

	// control state
	fsm_e_t                state_q, state_d;
	logic [CNTW-1:0]       count_q, count_d;
	status_e_t             status_q, status_d;
	logic                  rd_en_q, rd_en_d;
	logic [IDXW-1:0]       rpos_q;
	logic                  m_valid_q, m_valid_d;
	logic [OUT_W-1:0]      m_data_q;
	logic [OUT_USER_W-1:0] m_user_q;
	logic                  load_out;
	logic                  accept;
	cell_ctl_t             ctl;
	logic [15:0]           tgt16;

	assign cnt16 = 16'(count_q);
	assign accept = s_axis_tvalid && s_axis_tready;

	// decode of the operation against the current count
	always_comb begin
		status_d = ST_OK;
		rd_en_d  = 1'b0;
		count_d  = count_q;
		tgt16    = cnt16;
		ctl.cmd  = CMD_HOLD;
		ctl.pos  = '0;
		unique case (in_op)
			OP_APPEND, OP_INSERT: begin
				if (cnt16 >= CAP16) begin
					status_d = ST_FULL;
				end else begin
					tgt16   = (in_op == OP_APPEND || pos16 >= cnt16) ? cnt16 : pos16;
					ctl.cmd = CMD_INS;
					count_d = count_q + CNTW'(1);
				end
			end
			OP_READ: begin
				if (cnt16 == 16'd0) begin
					status_d = ST_EMPTY;
				end else if (pos16 >= cnt16) begin
					status_d = ST_RANGE;
				end else begin
					rd_en_d = 1'b1;
				end
			end
			OP_DEL_LAST, OP_DEL_POS: begin
				if (cnt16 == 16'd0) begin
					status_d = ST_EMPTY;
				end else begin
					tgt16 = (in_op == OP_DEL_LAST || pos16 >= cnt16) ?
						(cnt16 - 16'd1) : pos16;
					ctl.cmd = CMD_DEL;
					count_d = count_q - CNTW'(1);
				end
			end
			default: begin
				status_d = ST_RANGE;
			end
		endcase
		ctl.pos = tgt16[MAX_IDXW-1:0];
		if (!accept) begin
			ctl.cmd = CMD_HOLD;
		end
	end

	// row of cells
	logic                  cell_valid [CAPACITY];
	logic [DATA_WIDTH-1:0] cell_data  [CAPACITY];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                  pv, nv;
		logic [DATA_WIDTH-1:0] pd, nd;
		if (i == 0) begin : g_head
			assign pv = 1'b0;
			assign pd = '0;
		end else begin : g_mid
			assign pv = cell_valid[i-1];
			assign pd = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign nv = 1'b0;
			assign nd = '0;
		end else begin : g_body
			assign nv = cell_valid[i+1];
			assign nd = cell_data[i+1];
		end
		ple_cell #(
			.IDX        (i),
			.DATA_WIDTH (DATA_WIDTH)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.word       (in_word),
			.prev_valid (pv),
			.prev_data  (pd),
			.next_valid (nv),
			.next_data  (nd),
			.valid      (cell_valid[i]),
			.data       (cell_data[i])
		);
	end

	// gather read word and tail from the cells
	logic [DATA_WIDTH-1:0] rd_word, last_word, first_word;
	logic [15:0]           last16;
	logic [IDXW-1:0]       last_idx;
	logic [63:0]           rd_ext, last_ext, first_ext;
	logic [15:0]           cnt_out16;

	assign last16   = cnt16 - 16'd1;
	assign last_idx = last16[IDXW-1:0];

	always_comb begin
		rd_word   = '0;
		last_word = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (cell_valid[i] && rd_en_q && IDXW'(i) == rpos_q) begin
				rd_word = rd_word | cell_data[i];
			end
			if (cell_valid[i] && IDXW'(i) == last_idx) begin
				last_word = last_word | cell_data[i];
			end
		end
	end

	assign first_word = cell_valid[0] ? cell_data[0] : '0;
	assign rd_ext     = 64'(rd_word);
	assign last_ext   = 64'(last_word);
	assign first_ext  = 64'(first_word);
	assign cnt_out16  = 16'(count_q);

	// sequencer
	always_comb begin
		state_d   = state_q;
		load_out  = 1'b0;
		m_valid_d = m_valid_q;
		if (m_valid_q && m_axis_tready) begin
			m_valid_d = 1'b0;
		end
		unique case (state_q)
			FSM_IDLE: begin
				if (accept) begin
					state_d = FSM_EVAL;
				end
			end
			FSM_EVAL: begin
				if (!m_valid_q || m_axis_tready) begin
					load_out  = 1'b1;
					m_valid_d = 1'b1;
					state_d   = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	assign s_axis_tready = (state_q == FSM_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= FSM_IDLE;
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			m_valid_q <= m_valid_d;
			if (accept) begin
				count_q <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
			rd_en_q  <= rd_en_d;
			rpos_q   <= pos16[IDXW-1:0];
		end
		if (load_out) begin
			m_data_q <= {3'b000, last_ext[31:0], first_ext[31:0], cnt_out16[4:0],
				rd_ext[31:0]};
			m_user_q <= status_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

endmodule

// File: hw/rtl/ple_checker.sv
module ple_checker #(
	parameter int CAPACITY = 16
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [ple_pkg::OUT_W-1:0]      m_axis_tdata,
	input logic [ple_pkg::OUT_USER_W-1:0] m_axis_tuser
);
	import ple_pkg::*;

	logic [1:0]  o_status;
	logic [4:0]  o_count;
	logic [31:0] o_first;
	logic [31:0] o_last;
	logic [15:0] o_count16;
	logic        in_seen;

	assign o_status  = m_axis_tuser[1:0];
	assign o_count   = m_axis_tdata[36:32];
	assign o_first   = m_axis_tdata[68:37];
	assign o_last    = m_axis_tdata[100:69];
	assign o_count16 = 16'(o_count);
	assign in_seen   = s_axis_tvalid && s_axis_tready;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> o_count16 <= 16'(CAPACITY))
		else $error("count beyond capacity");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && o_status == ST_EMPTY) |-> (o_count == 5'd0))
		else $error("empty status with entries left");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && o_status == ST_FULL) |-> (o_count16 == 16'(CAPACITY)))
		else $error("full status below capacity");

	a_empty_words: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && o_count == 5'd0) |-> (o_first == 32'd0 && o_last == 32'd0))
		else $error("end words not zero on empty list");

	// a waiting result holds whether or not a new word comes in
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready && (in_seen || !in_seen)) |=>
		(m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
		else $error("stalled result changed");

endmodule

bind positional_list_engine_core ple_checker #(
	.CAPACITY (CAPACITY)
) u_ple_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

// File: bench/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ple_pkg::*;

	localparam int LIST_DEPTH = 16;
	localparam int WORD_W     = 32;

	// operation codes the block does not define
	localparam logic [2:0] OP_SPARE_A = 3'd5;
	localparam logic [2:0] OP_SPARE_B = 3'd6;
	localparam logic [2:0] OP_SPARE_C = 3'd7;

	typedef struct {
		logic [1:0]        status;
		logic [WORD_W-1:0] read_data;
		logic [4:0]        count;
		logic [WORD_W-1:0] first_word;
		logic [WORD_W-1:0] last_word;
	} list_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_W-1:0]       s_axis_tdata;
	logic [IN_USER_W-1:0]  s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_W-1:0]      m_axis_tdata;
	logic [OUT_USER_W-1:0] m_axis_tuser;

	// shadow copy of the list, advanced on every accepted word
	logic [WORD_W-1:0] shadow_words [LIST_DEPTH];
	int                shadow_len;
	list_result_t      pending_list_results [$];
	int                error_count;

	bit src_steady;
	bit sink_steady;
	int sink_pause_request;

	positional_list_engine_core #(
		.CAPACITY   (LIST_DEPTH),
		.DATA_WIDTH (WORD_W)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic list_result_t apply_list_op(input logic [2:0] op, input logic [4:0] pos,
			input logic [WORD_W-1:0] word);
		list_result_t res;
		int idx;
		res.status = ST_OK;
		res.read_data = '0;
		case (op)
			OP_APPEND, OP_INSERT: begin
				if (shadow_len >= LIST_DEPTH) begin
					res.status = ST_FULL;
				end else begin
					idx = (op == OP_APPEND || pos >= shadow_len) ? shadow_len : int'(pos);
					for (int i = shadow_len; i > idx; i--)
						shadow_words[i] = shadow_words[i-1];
					shadow_words[idx] = word;
					shadow_len++;
				end
			end
			OP_READ: begin
				if (shadow_len == 0)
					res.status = ST_EMPTY;
				else if (pos >= shadow_len)
					res.status = ST_RANGE;
				else
					res.read_data = shadow_words[pos];
			end
			OP_DEL_LAST, OP_DEL_POS: begin
				if (shadow_len == 0) begin
					res.status = ST_EMPTY;
				end else begin
					idx = (op == OP_DEL_LAST || pos >= shadow_len) ? shadow_len - 1 : int'(pos);
					for (int i = idx; i + 1 < shadow_len; i++)
						shadow_words[i] = shadow_words[i+1];
					shadow_len--;
				end
			end
			default: res.status = ST_RANGE;
		endcase
		res.count = shadow_len[4:0];
		res.first_word = (shadow_len != 0) ? shadow_words[0] : '0;
		res.last_word = (shadow_len != 0) ? shadow_words[shadow_len-1] : '0;
		return res;
	endfunction

	task automatic compare_field(input string name, input logic [WORD_W-1:0] want,
			input logic [WORD_W-1:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0h, actual %0h", name, want, got);
			error_count++;
		end
	endtask

	// results are checked before the new word is predicted, so a result
	// can never be matched against the word accepted at the same edge
	always @(posedge clk) begin : scoreboard
		list_result_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_list_results.size() == 0) begin
					$error("result word arrived with nothing expected");
					error_count++;
				end else begin
					want = pending_list_results.pop_front();
					compare_field("status", WORD_W'(want.status), WORD_W'(m_axis_tuser[1:0]));
					compare_field("read_data", want.read_data, m_axis_tdata[31:0]);
					compare_field("count", WORD_W'(want.count), WORD_W'(m_axis_tdata[36:32]));
					compare_field("first_word", want.first_word, m_axis_tdata[68:37]);
					compare_field("last_word", want.last_word, m_axis_tdata[100:69]);
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				pending_list_results.push_back(apply_list_op(s_axis_tuser[2:0],
					s_axis_tdata[4:0], s_axis_tdata[36:5]));
		end
	end

	// result side: draws a stall per word, or holds off on request
	initial begin : sink
		int gap;
		m_axis_tready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (sink_pause_request > 0) begin
				gap = sink_pause_request;
				sink_pause_request = 0;
				m_axis_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end else begin
				gap = sink_steady ? 0 : $urandom_range(0, 13);
				if (gap > 0) begin
					m_axis_tready <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	task automatic send_word(input logic [2:0] op, input logic [4:0] pos,
			input logic [WORD_W-1:0] word);
		int gap;
		gap = src_steady ? 0 : $urandom_range(0, 13);
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata <= {3'b000, word, pos};
		s_axis_tuser <= op;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic source_idle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
	endtask

	// the source stops offering first, so the last word is not taken again
	task automatic wait_results_drained();
		source_idle();
		while (pending_list_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [4:0] pick_position();
		if ($urandom_range(0, 3) != 0)
			return 5'($urandom_range(0, shadow_len));
		return 5'($urandom_range(0, 31));
	endfunction

	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(0, 19))
			0: return '0;
			1: return '1;
			2: return WORD_W'(1) << $urandom_range(0, WORD_W - 1);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [2:0] pick_spare_op();
		case ($urandom_range(0, 2))
			0: return OP_SPARE_A;
			1: return OP_SPARE_B;
			default: return OP_SPARE_C;
		endcase
	endfunction

	task automatic test_directed();
		send_word(OP_READ, 5'd0, '0);
		send_word(OP_DEL_LAST, 5'd0, '0);
		send_word(OP_DEL_POS, 5'd31, '1);
		send_word(OP_SPARE_A, 5'd0, 32'h1234_5678);
		send_word(OP_SPARE_B, 5'd16, '1);
		send_word(OP_SPARE_C, 5'd31, '0);
		send_word(OP_APPEND, 5'd0, '1);
		send_word(OP_APPEND, 5'd31, '0);
		send_word(OP_INSERT, 5'd0, 32'hA5A5_5A5A);
		send_word(OP_INSERT, 5'd1, 32'h0000_0001);
		send_word(OP_INSERT, 5'd31, 32'h8000_0000);
		send_word(OP_INSERT, 5'd5, 32'h7FFF_FFFF);
		send_word(OP_READ, 5'd0, '0);
		send_word(OP_READ, 5'd5, '0);
		send_word(OP_READ, 5'd6, '0);
		send_word(OP_READ, 5'd16, '0);
		send_word(OP_READ, 5'd31, '1);
		send_word(OP_DEL_POS, 5'd2, '0);
		send_word(OP_DEL_POS, 5'd0, '0);
		send_word(OP_DEL_POS, 5'd31, '0);
		send_word(OP_DEL_LAST, 5'd31, '1);
		send_word(OP_SPARE_C, 5'd1, '1);
		send_word(OP_SPARE_A, 5'd31, '1);
		send_word(OP_READ, 5'd1, '0);
	endtask

	// fill to capacity, push past it, then drain to empty and past it
	task automatic test_capacity();
		for (int round = 0; round < 2; round++) begin
			wait_results_drained();
			while (shadow_len < LIST_DEPTH)
				send_word($urandom_range(0, 1) ? OP_APPEND : OP_INSERT, pick_position(),
					pick_word());
			wait_results_drained();
			send_word(OP_APPEND, 5'd0, pick_word());
			send_word(OP_INSERT, 5'd0, pick_word());
			send_word(OP_INSERT, 5'd31, pick_word());
			send_word(OP_READ, 5'd15, '0);
			send_word(OP_READ, 5'd16, '0);
			send_word(OP_READ, 5'd0, '0);
			wait_results_drained();
			while (shadow_len > 0)
				send_word($urandom_range(0, 1) ? OP_DEL_LAST : OP_DEL_POS, pick_position(),
					pick_word());
			wait_results_drained();
			send_word(OP_DEL_LAST, 5'd0, '0);
			send_word(OP_DEL_POS, 5'd0, '0);
			send_word(OP_READ, 5'd0, '0);
		end
	endtask

	task automatic test_random_mix(input int n_words);
		bit grow;
		int r;
		logic [2:0] op;
		grow = 1'b1;
		for (int n = 0; n < n_words; n++) begin
			// stretches of 100 words in which each side, by its own draw, may never idle
			if (n % 100 == 0) begin
				src_steady = ($urandom_range(0, 3) == 0);
				sink_steady = ($urandom_range(0, 3) == 0);
			end
			if (shadow_len >= LIST_DEPTH)
				grow = 1'b0;
			else if (shadow_len == 0)
				grow = 1'b1;
			else if ($urandom_range(0, 49) == 0)
				grow = ~grow;
			r = $urandom_range(0, 99);
			if (r < 3)
				op = pick_spare_op();
			else if (r < 23)
				op = OP_READ;
			else if (grow)
				op = (r < 62) ? OP_APPEND : (r < 90) ? OP_INSERT : (r < 95) ? OP_DEL_LAST
					: OP_DEL_POS;
			else
				op = (r < 33) ? OP_APPEND : (r < 43) ? OP_INSERT : (r < 70) ? OP_DEL_LAST
					: OP_DEL_POS;
			send_word(op, pick_position(), pick_word());
		end
		src_steady = 1'b0;
		sink_steady = 1'b0;
	endtask

	// the result side holds off while words keep coming, so the input stalls
	task automatic test_output_stall();
		wait_results_drained();
		src_steady = 1'b1;
		sink_pause_request = 90;
		for (int n = 0; n < 40; n++)
			send_word(3'($urandom_range(0, 4)), pick_position(), pick_word());
		src_steady = 1'b0;
	endtask

	// the input side stops until every result is back, then resumes
	task automatic test_input_pause();
		for (int round = 0; round < 6; round++) begin
			for (int n = 0; n < 1 + round; n++)
				send_word(3'($urandom_range(0, 4)), pick_position(), pick_word());
			source_idle();
			wait_results_drained();
		end
	endtask

	initial begin
		error_count = 0;
		shadow_len = 0;
		src_steady = 1'b0;
		sink_steady = 1'b0;
		sink_pause_request = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_capacity();
		test_output_stall();
		test_input_pause();
		test_random_mix(1250);
		test_input_pause();

		source_idle();
		wait_results_drained();
		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("testbench: errors");
		$finish;
	end

endmodule

// File: files.f
hw/rtl/ple_pkg.sv
hw/rtl/ple_cell.sv
hw/rtl/positional_list_engine_core.sv
hw/rtl/ple_checker.sv
bench/testbench.sv
